### design/bbs_pkg.sv
package bbs_pkg;

   localparam int unsigned PIX_W        = 8;
   localparam int unsigned CSR_W        = 11;
   localparam int unsigned MAX_SIDE_DEF = 1024;
   localparam int unsigned SIDE_RESET   = 1024;
   localparam int unsigned SIDE_MIN     = 3;
   localparam int unsigned SUM_W        = 12;
   localparam int unsigned DIV9_MUL     = 7282;
   localparam int unsigned DIV9_MUL_W   = 13;
   localparam int unsigned DIV9_SHIFT   = 16;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type older;
      pixel_type newer;
      pixel_type current;
   } column_type;

   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } mark_type;

endpackage

### design/bbs_req_if.sv
interface bbs_req_if import bbs_pkg::*;;
   logic      valid;
   logic      ready;
   pixel_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

### design/bbs_rsp_if.sv
interface bbs_rsp_if import bbs_pkg::*;;
   logic      valid;
   logic      ready;
   pixel_type blurred_pixel;
   logic      row_end;
   logic      frame_end;

   modport source (output valid, output blurred_pixel, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input blurred_pixel, input row_end, input frame_end,
                 output ready);
endinterface

### design/bbs_line_store.sv
module bbs_line_store import bbs_pkg::*; #(
   parameter int unsigned MAX_SIDE = MAX_SIDE_DEF,
   parameter int unsigned POS_W    = $clog2(MAX_SIDE)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [POS_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [POS_W-1:0] wr_addr,
   input  pixel_type        wr_older,
   input  pixel_type        wr_newer,
   output pixel_type        rd_older,
   output pixel_type        rd_newer
);

   pixel_type older_mem_ff [MAX_SIDE];
   pixel_type newer_mem_ff [MAX_SIDE];
   pixel_type rd_older_ff;
   pixel_type rd_newer_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem_ff[wr_addr] <= wr_older;
         newer_mem_ff[wr_addr] <= wr_newer;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_older_ff <= older_mem_ff[rd_addr];
         rd_newer_ff <= newer_mem_ff[rd_addr];
      end
   end

   assign rd_older = rd_older_ff;
   assign rd_newer = rd_newer_ff;

endmodule

### design/bbs_mean_stage.sv
module bbs_mean_stage import bbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       restart,
   input  logic       in_valid,
   input  column_type in_col,
   input  mark_type   in_mark,
   output logic       in_ready,
   bbs_rsp_if.source  rsp_chan
);

   localparam int unsigned PROD_W = SUM_W + DIV9_MUL_W;

   column_type              win_ff [2];
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   pixel_type               mean_ff;
   logic                    row_end_ff;
   logic                    frame_end_ff;
   logic                    advance;
   logic [SUM_W-1:0]        sum;
   logic [PROD_W-1:0]       product;

   function automatic logic [SUM_W-1:0] column_sum(column_type col);
      return SUM_W'(col.older) + SUM_W'(col.newer) + SUM_W'(col.current);
   endfunction

   assign in_ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid && in_ready;

   assign sum     = column_sum(win_ff[0]) + column_sum(win_ff[1]) + column_sum(in_col);
   assign product = PROD_W'(sum) * PROD_W'(DIV9_MUL);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
      end else if (advance) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= in_col;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_mark.emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_mark.emit) begin
         mean_ff      <= product[DIV9_SHIFT +: PIX_W];
         row_end_ff   <= in_mark.row_end;
         frame_end_ff <= in_mark.frame_end;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.blurred_pixel = mean_ff;
   assign rsp_chan.row_end       = row_end_ff;
   assign rsp_chan.frame_end     = frame_end_ff;

endmodule

### design/box_blur_3x3_stream_core.sv
// Streaming 3x3 box filter over a square grayscale frame.
// A result passes the s1 registers, then the mean stage output register.
// Throughput: one pixel per clock unless the output stalls; the line store reads and
// writes one column a cycle. Reset: synchronous, active high; side returns to 1024,
// positions and window clear, line store contents are not cleared.
module box_blur_3x3_stream_core import bbs_pkg::*; #(
   parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   bbs_req_if.sink          req_chan,
   bbs_rsp_if.source        rsp_chan
);

   localparam int unsigned POS_W = $clog2(MAX_SIDE);
   localparam int unsigned CMP_W = (POS_W + 1 > CSR_W) ? POS_W + 1 : CSR_W;

   logic [CSR_W-1:0] side_ff;
   logic [POS_W-1:0] col_ff;
   logic [POS_W-1:0] row_ff;
   logic [POS_W-1:0] col_in;
   logic [POS_W-1:0] row_in;
   logic             s1_valid_ff;
   pixel_type        s1_px_ff;
   mark_type         s1_mark_ff;
   logic [POS_W-1:0] s1_addr_ff;
   logic [CMP_W-1:0] side_ext;
   logic [POS_W-1:0] side_last;
   logic             accept;
   logic             advance;
   logic             mean_ready;
   mark_type         mark_in;
   column_type       cur_col;
   pixel_type        rd_older;
   pixel_type        rd_newer;

   assign side_ext = CMP_W'(side_ff);

   always_comb begin
      if (side_ext < CMP_W'(SIDE_MIN)) begin
         side_last = POS_W'(SIDE_MIN - 1);
      end else if (side_ext > CMP_W'(MAX_SIDE)) begin
         side_last = POS_W'(MAX_SIDE - 1);
      end else begin
         side_last = POS_W'(side_ext - CMP_W'(1));
      end
   end

   assign req_chan.ready = !s1_valid_ff || mean_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign advance        = s1_valid_ff && mean_ready;

   always_comb begin
      mark_in.emit      = (row_ff >= POS_W'(2)) && (col_ff >= POS_W'(2));
      mark_in.row_end   = (col_ff == side_last);
      mark_in.frame_end = (col_ff == side_last) && (row_ff == side_last);
   end

   // advance raster position
   always_comb begin
      col_in = col_ff + POS_W'(1);
      row_in = row_ff;
      if (col_ff == side_last) begin
         col_in = '0;
         row_in = (row_ff == side_last) ? '0 : row_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= CSR_W'(SIDE_RESET);
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (csr_wr_en) begin
         side_ff <= csr_wr_data;
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_chan.pixel_in;
         s1_mark_ff <= mark_in;
         s1_addr_ff <= col_ff;
      end
   end

   bbs_line_store #(
      .MAX_SIDE (MAX_SIDE),
      .POS_W    (POS_W)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (col_ff),
      .wr_en    (advance),
      .wr_addr  (s1_addr_ff),
      .wr_older (rd_newer),
      .wr_newer (s1_px_ff),
      .rd_older (rd_older),
      .rd_newer (rd_newer)
   );

   assign cur_col.older   = rd_older;
   assign cur_col.newer   = rd_newer;
   assign cur_col.current = s1_px_ff;

   bbs_mean_stage u_mean_stage (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wr_en),
      .in_valid (s1_valid_ff),
      .in_col   (cur_col),
      .in_mark  (s1_mark_ff),
      .in_ready (mean_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

### tb/box_blur_3x3_stream_core_test.sv
`timescale 1ns / 1ps

module box_blur_3x3_stream_core_test;
   import bbs_pkg::*;

   localparam int unsigned KERNEL_TAPS  = 9;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned SMALL_SIDE   = 14;
   localparam int unsigned HEAD_ITEMS   = 40;

   typedef struct packed {
      pixel_type blurred;
      logic      row_end;
      logic      frame_end;
   } blur_result_type;

   class blur_scoreboard;
      logic [CSR_W-1:0] side_reg;
      pixel_type        older_row [MAX_SIDE_DEF];
      pixel_type        newer_row [MAX_SIDE_DEF];
      column_type       window_q [2];
      int unsigned      col_pos;
      int unsigned      row_pos;
      blur_result_type  expected_q [$];
      int unsigned      errors;

      function new();
         side_reg = CSR_W'(SIDE_RESET);
         errors   = 0;
         foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
         end
         restart();
      endfunction

      function void restart();
         window_q[0] = '0;
         window_q[1] = '0;
         col_pos     = 0;
         row_pos     = 0;
      endfunction

      function void write_side(logic [CSR_W-1:0] value);
         side_reg = value;
         restart();
      endfunction

      function int unsigned side_eff();
         if (side_reg < SIDE_MIN) return SIDE_MIN;
         if (side_reg > MAX_SIDE_DEF) return MAX_SIDE_DEF;
         return side_reg;
      endfunction

      function int unsigned column_total(column_type c);
         return int'(c.older) + int'(c.newer) + int'(c.current);
      endfunction

      function void note_pixel(pixel_type px);
         int unsigned     side;
         int unsigned     sum;
         column_type      col;
         blur_result_type res;
         side        = side_eff();
         col.older   = older_row[col_pos];
         col.newer   = newer_row[col_pos];
         col.current = px;
         older_row[col_pos] = col.newer;
         newer_row[col_pos] = px;
         if (row_pos >= 2 && col_pos >= 2) begin
            sum = column_total(window_q[0]) + column_total(window_q[1]) + column_total(col);
            res.blurred   = pixel_type'(sum / KERNEL_TAPS);
            res.row_end   = (col_pos == side - 1);
            res.frame_end = res.row_end && (row_pos == side - 1);
            expected_q.push_back(res);
         end
         window_q[0] = window_q[1];
         window_q[1] = col;
         col_pos++;
         if (col_pos >= side) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= side) row_pos = 0;
         end
      endfunction

      task report(string what);
         $display("%0t: mismatch, %s", $time, what);
         errors++;
      endtask

      task check_result(pixel_type blurred, logic row_end, logic frame_end);
         blur_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result blurred=%0d", blurred));
            return;
         end
         want = expected_q.pop_front();
         if (blurred !== want.blurred)
            report($sformatf("blurred_pixel %0d, want %0d", blurred, want.blurred));
         if (row_end !== want.row_end)
            report($sformatf("row_end %0b, want %0b", row_end, want.row_end));
         if (frame_end !== want.frame_end)
            report($sformatf("frame_end %0b, want %0b", frame_end, want.frame_end));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;
   int unsigned      src_idle_pct;
   int unsigned      snk_idle_pct;
   int unsigned      stall_cycles;
   blur_scoreboard   sb;

   bbs_req_if req_chan ();
   bbs_rsp_if rsp_chan ();

   box_blur_3x3_stream_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_result(rsp_chan.blurred_pixel, rsp_chan.row_end, rsp_chan.frame_end);
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic pixel_type gen_pixel(bit stark);
      if (stark) return $urandom_range(1) ? 8'hFF : 8'h00;
      return pixel_type'($urandom_range(255));
   endfunction

   task automatic set_idling(int unsigned mode);
      case (mode)
         0: begin
            src_idle_pct = 37;
            snk_idle_pct = 87;
         end
         1: begin
            src_idle_pct = 87;
            snk_idle_pct = 37;
         end
         default: begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_pixel(pixel_type px);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.pixel_in <= px;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_pixel(px);
      @(negedge clock);
   endtask

   task automatic send_pixels(int unsigned count, bit stark);
      for (int unsigned i = 0; i < count; i++) send_pixel(gen_pixel(stark));
      req_chan.valid <= 1'b0;
   endtask

   // hold until the pipeline is empty, then write
   task automatic write_side(logic [CSR_W-1:0] value);
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.write_side(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned      phase_no;
      int unsigned      small_items;
      int unsigned      eff;
      int unsigned      count;
      logic [CSR_W-1:0] side;
      bit               stark;
      sb                = new();
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_chan.valid    = 1'b0;
      req_chan.pixel_in = '0;
      set_idling(0);
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hold the reset side: too few pixels for a result
      send_pixels(HEAD_ITEMS, 1'b0);

      write_side(CSR_W'(SIDE_MIN));
      repeat (KERNEL_TAPS) send_pixel(8'hFF);
      for (int unsigned i = 0; i < KERNEL_TAPS; i++) send_pixel((i % 2) ? 8'h00 : 8'hFF);
      req_chan.valid <= 1'b0;

      phase_no    = 0;
      small_items = 0;
      while (small_items < RANDOM_ITEMS) begin
         set_idling(small_items * 3 / RANDOM_ITEMS);
         if (phase_no < SIDE_MIN) side = CSR_W'(phase_no);
         else if (phase_no == SIDE_MIN) side = '1;
         else side = CSR_W'($urandom_range(SIDE_MIN, SMALL_SIDE));
         write_side(side);
         eff   = (side < SIDE_MIN) ? SIDE_MIN : (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side;
         stark = ($urandom_range(3) == 0);
         if (eff == MAX_SIDE_DEF) begin
            count = $urandom_range(3, 40);
         end else begin
            count = eff * eff * ((eff <= 8) ? $urandom_range(1, 3) : 1);
            if ($urandom_range(1)) count += $urandom_range(1, eff * eff - 1);
            small_items += count;
         end
         send_pixels(count, stark);
         phase_no++;
      end

      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
